@@ rtl/nmdf_pkg.sv @@
// ----------------------------------------------------------------------------
// nmdf_pkg
// Shared constants, command and status codes, and the result record of the
// downlink MAC PDU framer.
// ----------------------------------------------------------------------------
package nmdf_pkg;

    // PDU buffer geometry
    localparam int BUF_BYTES = 16384;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int OFS_W     = ADDR_W + 1;

    // Command codes
    localparam logic [2:0] FUNC_BEGIN  = 3'd0;
    localparam logic [2:0] FUNC_SDU    = 3'd1;
    localparam logic [2:0] FUNC_DATA   = 3'd2;
    localparam logic [2:0] FUNC_TA     = 3'd3;
    localparam logic [2:0] FUNC_CONRES = 3'd4;
    localparam logic [2:0] FUNC_FINISH = 3'd5;
    localparam logic [2:0] FUNC_READ   = 3'd6;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_ORDER    = 2'd3;

    // Subheader LCIDs
    localparam logic [5:0] LCID_TA_CMD = 6'd61;
    localparam logic [5:0] LCID_CONRES = 6'd62;
    localparam logic [5:0] LCID_PAD    = 6'd63;

    // One finished result from the sequencer
    typedef struct packed {
        logic             valid;
        logic [1:0]       status;
        logic [16:0]      bytes_added;
        logic [OFS_W-1:0] fill_level;
        logic [7:0]       read_byte;
    } res_t;

endpackage

@@ rtl/nmdf_pdu_ram.sv @@
// ----------------------------------------------------------------------------
// nmdf_pdu_ram
// Simple dual-port byte RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nmdf_pdu_ram #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/nmdf_ctrl.sv @@
// ----------------------------------------------------------------------------
// nmdf_ctrl
// Command sequencer: checks each request against the PDU state, writes
// subheader, CE, payload and padding bytes into the buffer RAM one per cycle,
// and issues buffer reads.
// ----------------------------------------------------------------------------
module nmdf_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        out_free,
    input  logic [2:0]                  func,
    input  logic [5:0]                  chan_id,
    input  logic [15:0]                 length,
    input  logic [7:0]                  data_byte,
    input  logic [1:0]                  tag_id,
    input  logic [5:0]                  ta_value,
    input  logic [47:0]                 conres_id,
    input  logic [nmdf_pkg::ADDR_W-1:0] read_addr,
    output logic                        ram_wr_en,
    output logic [nmdf_pkg::ADDR_W-1:0] ram_wr_addr,
    output logic [7:0]                  ram_wr_data,
    output logic                        ram_rd_en,
    output logic [nmdf_pkg::ADDR_W-1:0] ram_rd_addr,
    input  logic [7:0]                  ram_rd_data,
    output nmdf_pkg::res_t              res
);

    localparam int OFS_W = nmdf_pkg::OFS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_FILL,
        S_RDATA
    } state_t;

    state_t           state_reg, state_next;
    logic [OFS_W-1:0] offset_reg, offset_next;
    logic [OFS_W-1:0] block_reg, block_next;
    logic [15:0]      left_reg, left_next;
    logic [55:0]      seq_bytes_reg, seq_bytes_next;
    logic [2:0]       seq_cnt_reg, seq_cnt_next;
    logic             pad_first_reg, pad_first_next;
    logic [1:0]       status_reg, status_next;
    logic [16:0]      added_reg, added_next;

    logic             accept;
    logic             hdr3;
    logic [17:0]      sdu_need;
    logic [17:0]      end_sdu;
    logic [17:0]      end_ta;
    logic [17:0]      end_conres;
    logic [17:0]      block_ext;
    logic [OFS_W-1:0] offset_inc;

    assign in_ready   = (state_reg == S_IDLE) && out_free;
    assign accept     = in_valid && in_ready;
    assign offset_inc = offset_reg + OFS_W'(1);

    // space checks for subheaders and CEs
    assign hdr3       = (length[15:8] != 8'd0);
    assign sdu_need   = 18'(length) + (hdr3 ? 18'd3 : 18'd2);
    assign block_ext  = 18'(block_reg);
    assign end_sdu    = 18'(offset_reg) + sdu_need;
    assign end_ta     = 18'(offset_reg) + 18'd2;
    assign end_conres = 18'(offset_reg) + 18'd7;

    // next state and buffer accesses
    always_comb
    begin
        state_next     = state_reg;
        offset_next    = offset_reg;
        block_next     = block_reg;
        left_next      = left_reg;
        seq_bytes_next = seq_bytes_reg;
        seq_cnt_next   = seq_cnt_reg;
        pad_first_next = pad_first_reg;
        status_next    = status_reg;
        added_next     = added_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = offset_reg[OFS_W-2:0];
        ram_wr_data    = 8'd0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = read_addr;
        res            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // answers decided on acceptance report at once
                    res.valid       = 1'b1;
                    res.status      = nmdf_pkg::ST_OK;
                    res.bytes_added = 17'd0;
                    res.fill_level  = offset_reg;
                    unique case (func)
                        nmdf_pkg::FUNC_BEGIN:
                        begin
                            offset_next    = '0;
                            left_next      = 16'd0;
                            res.fill_level = '0;
                            if (17'(length) > 17'(nmdf_pkg::BUF_BYTES))
                            begin
                                block_next = OFS_W'(nmdf_pkg::BUF_BYTES);
                                res.status = nmdf_pkg::ST_NOSPACE;
                            end
                            else
                            begin
                                block_next = OFS_W'(length);
                            end
                        end
                        nmdf_pkg::FUNC_SDU:
                        begin
                            if (left_reg != 16'd0 || length == 16'd0)
                            begin
                                res.status = nmdf_pkg::ST_ORDER;
                            end
                            else if (end_sdu > block_ext)
                            begin
                                res.status = nmdf_pkg::ST_NOSPACE;
                            end
                            else
                            begin
                                res.valid    = 1'b0;
                                left_next    = length;
                                status_next  = nmdf_pkg::ST_OK;
                                added_next   = sdu_need[16:0];
                                state_next   = S_WRITE;
                                if (hdr3)
                                begin
                                    seq_bytes_next = {2'b01, chan_id, length, 32'd0};
                                    seq_cnt_next   = 3'd3;
                                end
                                else
                                begin
                                    seq_bytes_next = {2'b00, chan_id, length[7:0], 40'd0};
                                    seq_cnt_next   = 3'd2;
                                end
                            end
                        end
                        nmdf_pkg::FUNC_DATA:
                        begin
                            if (left_reg == 16'd0)
                            begin
                                res.status = nmdf_pkg::ST_ORDER;
                            end
                            else
                            begin
                                ram_wr_en       = 1'b1;
                                ram_wr_data     = data_byte;
                                offset_next     = offset_inc;
                                left_next       = left_reg - 16'd1;
                                res.bytes_added = 17'd1;
                                res.fill_level  = offset_inc;
                            end
                        end
                        nmdf_pkg::FUNC_TA:
                        begin
                            if (left_reg != 16'd0)
                            begin
                                res.status = nmdf_pkg::ST_ORDER;
                            end
                            else if (end_ta > block_ext)
                            begin
                                res.status = nmdf_pkg::ST_NOSPACE;
                            end
                            else
                            begin
                                res.valid      = 1'b0;
                                status_next    = nmdf_pkg::ST_OK;
                                added_next     = 17'd2;
                                seq_bytes_next = {2'b00, nmdf_pkg::LCID_TA_CMD,
                                                  tag_id, ta_value, 40'd0};
                                seq_cnt_next   = 3'd2;
                                state_next     = S_WRITE;
                            end
                        end
                        nmdf_pkg::FUNC_CONRES:
                        begin
                            if (left_reg != 16'd0)
                            begin
                                res.status = nmdf_pkg::ST_ORDER;
                            end
                            else if (end_conres > block_ext)
                            begin
                                res.status = nmdf_pkg::ST_NOSPACE;
                            end
                            else
                            begin
                                res.valid      = 1'b0;
                                status_next    = nmdf_pkg::ST_OK;
                                added_next     = 17'd7;
                                seq_bytes_next = {2'b00, nmdf_pkg::LCID_CONRES, conres_id};
                                seq_cnt_next   = 3'd7;
                                state_next     = S_WRITE;
                            end
                        end
                        nmdf_pkg::FUNC_FINISH:
                        begin
                            if (left_reg != 16'd0)
                            begin
                                res.status = nmdf_pkg::ST_ORDER;
                            end
                            else if (offset_reg > block_reg)
                            begin
                                res.status = nmdf_pkg::ST_OVERFLOW;
                            end
                            else if (offset_reg < block_reg)
                            begin
                                res.valid      = 1'b0;
                                status_next    = nmdf_pkg::ST_OK;
                                added_next     = 17'(block_reg - offset_reg);
                                pad_first_next = 1'b1;
                                state_next     = S_FILL;
                            end
                        end
                        nmdf_pkg::FUNC_READ:
                        begin
                            res.valid   = 1'b0;
                            ram_rd_en   = 1'b1;
                            status_next = nmdf_pkg::ST_OK;
                            added_next  = 17'd0;
                            state_next  = S_RDATA;
                        end
                        default:
                        begin
                            res.status = nmdf_pkg::ST_ORDER;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                // subheader / CE bytes, most significant first
                ram_wr_en      = 1'b1;
                ram_wr_data    = seq_bytes_reg[55:48];
                offset_next    = offset_inc;
                seq_bytes_next = {seq_bytes_reg[47:0], 8'd0};
                seq_cnt_next   = seq_cnt_reg - 3'd1;
                if (seq_cnt_reg == 3'd1)
                begin
                    res.valid       = 1'b1;
                    res.status      = status_reg;
                    res.bytes_added = added_reg;
                    res.fill_level  = offset_inc;
                    state_next      = S_IDLE;
                end
            end
            S_FILL:
            begin
                // padding subheader, then zero fill to the block size
                ram_wr_en      = 1'b1;
                ram_wr_data    = pad_first_reg ? {2'b00, nmdf_pkg::LCID_PAD} : 8'd0;
                offset_next    = offset_inc;
                pad_first_next = 1'b0;
                if (offset_inc == block_reg)
                begin
                    res.valid       = 1'b1;
                    res.status      = status_reg;
                    res.bytes_added = added_reg;
                    res.fill_level  = offset_inc;
                    state_next      = S_IDLE;
                end
            end
            S_RDATA:
            begin
                res.valid       = 1'b1;
                res.status      = status_reg;
                res.bytes_added = added_reg;
                res.fill_level  = offset_reg;
                res.read_byte   = ram_rd_data;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            offset_reg    <= '0;
            block_reg     <= '0;
            left_reg      <= 16'd0;
            seq_bytes_reg <= 56'd0;
            seq_cnt_reg   <= 3'd0;
            pad_first_reg <= 1'b0;
            status_reg    <= nmdf_pkg::ST_OK;
            added_reg     <= 17'd0;
        end
        else
        begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            block_reg     <= block_next;
            left_reg      <= left_next;
            seq_bytes_reg <= seq_bytes_next;
            seq_cnt_reg   <= seq_cnt_next;
            pad_first_reg <= pad_first_next;
            status_reg    <= status_next;
            added_reg     <= added_next;
        end
    end

endmodule

@@ rtl/nr_mac_dl_pdu_framer.sv @@
// ----------------------------------------------------------------------------
// nr_mac_dl_pdu_framer
// Downlink MAC PDU framer: builds one PDU of subheaders, SDU payload, CEs and
// padding in an on-chip byte buffer and reads it back byte by byte.
// ----------------------------------------------------------------------------
// One request in, one result out, one request in flight at a time. Begin,
// payload byte and every rejected request are answered from idle, so SDU
// payload streams at one byte per clock while each result is taken at the
// output. An SDU subheader writes 2 or 3 bytes, a timing advance CE 2, a
// contention resolution CE 7 and finish its padding bytes, all through the
// buffer RAM's single write port, which takes one byte per cycle; a read
// waits for the registered RAM output. A new request is taken while the
// previous result is being taken at the output. The buffer needs no clearing
// after reset; reading a byte never written returns an arbitrary value.
module nr_mac_dl_pdu_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [5:0]  chan_id,
    input  logic [15:0] length,
    input  logic [7:0]  data_byte,
    input  logic [1:0]  tag_id,
    input  logic [5:0]  ta_value,
    input  logic [47:0] conres_id,
    input  logic [13:0] read_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [16:0] bytes_added,
    output logic [14:0] fill_level,
    output logic [7:0]  read_byte
);

    localparam int ADDR_W = nmdf_pkg::ADDR_W;

    nmdf_pkg::res_t    res;
    logic              out_free;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [16:0]       bytes_added_reg;
    logic [14:0]       fill_level_reg;
    logic [7:0]        read_byte_reg;

    assign out_free = !out_valid_reg || out_ready;

    nmdf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_free    (out_free),
        .func        (func),
        .chan_id     (chan_id),
        .length      (length),
        .data_byte   (data_byte),
        .tag_id      (tag_id),
        .ta_value    (ta_value),
        .conres_id   (conres_id),
        .read_addr   (read_addr),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res         (res)
    );

    nmdf_pdu_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (8)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg      <= res.status;
            bytes_added_reg <= res.bytes_added;
            fill_level_reg  <= res.fill_level;
            read_byte_reg   <= res.read_byte;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign bytes_added = bytes_added_reg;
    assign fill_level  = fill_level_reg;
    assign read_byte   = read_byte_reg;

    // a new result never overwrites one still waiting at the output
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        res.valid |-> (!out_valid_reg || out_ready))
        else $error("result produced while output register is occupied");

    // overflow at finish cannot arise once every append is space checked
    a_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.status != nmdf_pkg::ST_OVERFLOW))
        else $error("write offset passed the block size");

    // the write offset stays within the buffer
    a_fill_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.fill_level <= 15'(nmdf_pkg::BUF_BYTES)))
        else $error("fill level beyond buffer size");

    // a request is taken only while no RAM write from an earlier one is pending
    a_accept_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!ram_wr_en || !in_ready || res.valid))
        else $error("request accepted during a multi-byte write");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the downlink MAC PDU framer. A directed table walks
// the error paths, subheader forms and a full-size PDU, then random PDUs with
// random SDU, CE, read and noise requests follow. Results are checked against
// typed table rows or an in-bench copy of the framer's byte image and offsets.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [2:0] FUNC_UNDEF = 3'd7;
    localparam int L8_LIMIT    = 256;
    localparam int N_DIR       = 31;
    localparam int N_RAND      = 920;
    localparam int IDLE_PCT    = 34;
    localparam int RX_HOLD     = 400;
    localparam int TAIL_CYC    = 16;
    localparam int STALL_LIMIT = 60000;

    // One framer request and one framer result
    typedef struct packed {
        logic [2:0]  func;
        logic [5:0]  chan;
        logic [15:0] len;
        logic [7:0]  data;
        logic [1:0]  tag;
        logic [5:0]  ta;
        logic [47:0] crid;
        logic [13:0] raddr;
    } req_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [16:0] added;
        logic [14:0] fill;
        logic [7:0]  rbyte;
    } pdu_res_t;

    typedef struct packed {
        req_t     r;
        int       reps;
        bit       typed;
        pdu_res_t want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  func = '0;
    logic [5:0]  chan_id = '0;
    logic [15:0] length = '0;
    logic [7:0]  data_byte = '0;
    logic [1:0]  tag_id = '0;
    logic [5:0]  ta_value = '0;
    logic [47:0] conres_id = '0;
    logic [13:0] read_addr = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [16:0] bytes_added;
    logic [14:0] fill_level;
    logic [7:0]  read_byte;

    // Predicted framer state
    logic [7:0] pdu_img [nmdf_pkg::BUF_BYTES];
    int         img_ofs = 0;
    int         img_blk = 0;
    int         img_owed = 0;

    pdu_res_t   res_q [$];
    int         err_cnt = 0;
    int         stall_cyc = 0;
    bit         pdu_open = 1'b0;
    bit         tx_fast = 1'b0;
    bit         rx_fast = 1'b0;
    int         hold_go = 0;
    int         hold_seen = 0;
    pdu_res_t   got;
    pdu_res_t   want;

    // Directed requests; typed rows carry the result read straight off the spec
    row_t dir_tab [N_DIR] = '{
        '{'{nmdf_pkg::FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_SDU, 5, 5, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_NOSPACE, 0, 0, 0}},
        '{'{FUNC_UNDEF, 0, 0, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_ORDER, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_DATA, 0, 0, 8'h5a, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_ORDER, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_BEGIN, 0, 16'hffff, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_NOSPACE, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_BEGIN, 0, 0, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_TA, 0, 0, 0, 1, 9, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_NOSPACE, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_BEGIN, 0, 40, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_SDU, 1, 0, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_ORDER, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_SDU, 63, 3, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 5, 2, 0}},
        '{'{nmdf_pkg::FUNC_TA, 0, 0, 0, 2, 5, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_ORDER, 0, 2, 0}},
        '{'{nmdf_pkg::FUNC_CONRES, 0, 0, 0, 0, 0, 48'h1, 0}, 1, 1,
          '{nmdf_pkg::ST_ORDER, 0, 2, 0}},
        '{'{nmdf_pkg::FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_ORDER, 0, 2, 0}},
        '{'{nmdf_pkg::FUNC_DATA, 0, 0, 8'hff, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 1, 3, 0}},
        '{'{nmdf_pkg::FUNC_DATA, 0, 0, 8'ha5, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 1, 4, 0}},
        '{'{nmdf_pkg::FUNC_DATA, 0, 0, 8'h00, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 1, 5, 0}},
        '{'{nmdf_pkg::FUNC_TA, 0, 0, 0, 3, 63, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 2, 7, 0}},
        '{'{nmdf_pkg::FUNC_CONRES, 0, 0, 0, 0, 0, 48'hffff_ffff_ffff, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 7, 14, 0}},
        '{'{nmdf_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 7}, 1, 0,
          '{nmdf_pkg::ST_OK, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_SDU, 2, 30, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_NOSPACE, 0, 14, 0}},
        '{'{nmdf_pkg::FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 26, 40, 0}},
        '{'{nmdf_pkg::FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 0, 40, 0}},
        '{'{nmdf_pkg::FUNC_BEGIN, 0, 600, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_SDU, 42, 300, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 303, 3, 0}},
        '{'{nmdf_pkg::FUNC_DATA, 0, 0, 0, 0, 0, 0, 0}, 300, 0,
          '{nmdf_pkg::ST_OK, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_SDU, 0, 16'hffff, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_NOSPACE, 0, 303, 0}},
        '{'{nmdf_pkg::FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 297, 600, 0}},
        '{'{nmdf_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 1}, 1, 0,
          '{nmdf_pkg::ST_OK, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_BEGIN, 0, 16384, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 0, 0, 0}},
        '{'{nmdf_pkg::FUNC_FINISH, 0, 0, 0, 0, 0, 0, 0}, 1, 1,
          '{nmdf_pkg::ST_OK, 16384, 16384, 0}},
        '{'{nmdf_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 16383}, 1, 1,
          '{nmdf_pkg::ST_OK, 0, 16384, 0}}
    };

    nr_mac_dl_pdu_framer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .chan_id     (chan_id),
        .length      (length),
        .data_byte   (data_byte),
        .tag_id      (tag_id),
        .ta_value    (ta_value),
        .conres_id   (conres_id),
        .read_addr   (read_addr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .bytes_added (bytes_added),
        .fill_level  (fill_level),
        .read_byte   (read_byte)
    );

    always #5 clk = ~clk;

    // Append one byte to the predicted PDU image
    function automatic void push_byte(logic [7:0] b);
        if (img_ofs < nmdf_pkg::BUF_BYTES)
        begin
            pdu_img[img_ofs] = b;
        end
        img_ofs++;
    endfunction

    // Apply one request to the predicted framer state, return its result
    function automatic pdu_res_t frame_cmd(req_t r);
        pdu_res_t o;
        int       hdr;
        o = '0;
        o.st = nmdf_pkg::ST_OK;
        hdr = (int'(r.len) < L8_LIMIT) ? 2 : 3;
        case (r.func)
            nmdf_pkg::FUNC_BEGIN:
            begin
                img_ofs = 0;
                img_owed = 0;
                if (int'(r.len) > nmdf_pkg::BUF_BYTES)
                begin
                    img_blk = nmdf_pkg::BUF_BYTES;
                    o.st = nmdf_pkg::ST_NOSPACE;
                end
                else
                begin
                    img_blk = int'(r.len);
                end
            end
            nmdf_pkg::FUNC_SDU:
            begin
                if (img_owed != 0 || r.len == 16'd0)
                begin
                    o.st = nmdf_pkg::ST_ORDER;
                end
                else if (img_ofs + hdr + int'(r.len) > img_blk)
                begin
                    o.st = nmdf_pkg::ST_NOSPACE;
                end
                else
                begin
                    // R/F/LCID, then L (16-bit form when long)
                    push_byte({1'b0, (hdr == 3), r.chan});
                    if (hdr == 3)
                    begin
                        push_byte(r.len[15:8]);
                    end
                    push_byte(r.len[7:0]);
                    img_owed = int'(r.len);
                    o.added = 17'(hdr + int'(r.len));
                end
            end
            nmdf_pkg::FUNC_DATA:
            begin
                if (img_owed == 0)
                begin
                    o.st = nmdf_pkg::ST_ORDER;
                end
                else
                begin
                    push_byte(r.data);
                    img_owed--;
                    o.added = 17'd1;
                end
            end
            nmdf_pkg::FUNC_TA:
            begin
                if (img_owed != 0)
                begin
                    o.st = nmdf_pkg::ST_ORDER;
                end
                else if (img_ofs + 2 > img_blk)
                begin
                    o.st = nmdf_pkg::ST_NOSPACE;
                end
                else
                begin
                    push_byte({2'b00, nmdf_pkg::LCID_TA_CMD});
                    push_byte({r.tag, r.ta});
                    o.added = 17'd2;
                end
            end
            nmdf_pkg::FUNC_CONRES:
            begin
                if (img_owed != 0)
                begin
                    o.st = nmdf_pkg::ST_ORDER;
                end
                else if (img_ofs + 7 > img_blk)
                begin
                    o.st = nmdf_pkg::ST_NOSPACE;
                end
                else
                begin
                    push_byte({2'b00, nmdf_pkg::LCID_CONRES});
                    for (int i = 0; i < 6; i++)
                    begin
                        push_byte(r.crid[47 - 8 * i -: 8]);
                    end
                    o.added = 17'd7;
                end
            end
            nmdf_pkg::FUNC_FINISH:
            begin
                if (img_owed != 0)
                begin
                    o.st = nmdf_pkg::ST_ORDER;
                end
                else if (img_ofs > img_blk)
                begin
                    o.st = nmdf_pkg::ST_OVERFLOW;
                end
                else if (img_ofs < img_blk)
                begin
                    // padding subheader plus zero fill to the block end
                    o.added = 17'(img_blk - img_ofs);
                    push_byte({2'b00, nmdf_pkg::LCID_PAD});
                    while (img_ofs < img_blk)
                    begin
                        push_byte(8'h00);
                    end
                end
            end
            nmdf_pkg::FUNC_READ:
            begin
                o.rbyte = pdu_img[r.raddr];
            end
            default:
            begin
                o.st = nmdf_pkg::ST_ORDER;
            end
        endcase
        o.fill = 15'(img_ofs);
        return o;
    endfunction

    // Offer one request, wait for it to be taken, queue its expected result
    task automatic send_req(req_t r, bit typed, pdu_res_t fixed);
        int       gap;
        pdu_res_t pred;
        gap = 0;
        while (!tx_fast && $urandom_range(0, 99) < IDLE_PCT)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func      <= r.func;
        chan_id   <= r.chan;
        length    <= r.len;
        data_byte <= r.data;
        tag_id    <= r.tag;
        ta_value  <= r.ta;
        conres_id <= r.crid;
        read_addr <= r.raddr;
        in_valid  <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (in_ready)
            begin
                break;
            end
        end
        pred = frame_cmd(r);
        res_q.push_back(typed ? fixed : pred);
    endtask

    // Stop offering until every expected result is back, then let it settle
    task automatic drain(int tail);
        in_valid <= 1'b0;
        while (res_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (tail) @(posedge clk);
    endtask

    // Random request: mostly well-formed PDUs, with some noise mixed in
    task automatic pick_req(output req_t r);
        int p;
        int q;
        int rem;
        r.func  = nmdf_pkg::FUNC_READ;
        r.chan  = 6'($urandom_range(0, 63));
        r.len   = 16'($urandom_range(0, 65535));
        r.data  = 8'($urandom_range(0, 255));
        r.tag   = 2'($urandom_range(0, 3));
        r.ta    = 6'($urandom_range(0, 63));
        r.crid  = {16'($urandom_range(0, 65535)), 32'($urandom)};
        r.raddr = 14'($urandom_range(0, nmdf_pkg::BUF_BYTES - 1));
        if (img_owed != 0)
        begin
            if ($urandom_range(0, 99) < 2)
            begin
                r.func = 3'($urandom_range(1, 7));
            end
            else
            begin
                r.func = nmdf_pkg::FUNC_DATA;
            end
        end
        else if (!pdu_open)
        begin
            r.func = nmdf_pkg::FUNC_BEGIN;
            p = $urandom_range(0, 99);
            if (p < 70)
            begin
                r.len = 16'($urandom_range(8, 160));
            end
            else if (p < 92)
            begin
                r.len = 16'($urandom_range(161, 1200));
            end
            else if (p < 98)
            begin
                r.len = 16'($urandom_range(0, 7));
            end
        end
        else
        begin
            p = $urandom_range(0, 99);
            if (p < 55)
            begin
                r.func = nmdf_pkg::FUNC_SDU;
                q = $urandom_range(0, 99);
                rem = img_blk - img_ofs;
                if (q < 70)
                begin
                    r.len = 16'($urandom_range(1, 24));
                end
                else if (q < 82)
                begin
                    r.len = 16'($urandom_range(240, 270));
                end
                else if (q < 95)
                begin
                    // try to land exactly on the block end
                    if (rem - 2 >= 1 && rem - 2 < L8_LIMIT)
                    begin
                        r.len = 16'(rem - 2);
                    end
                    else if (rem - 3 >= L8_LIMIT)
                    begin
                        r.len = 16'(rem - 3);
                    end
                    else
                    begin
                        r.len = 16'd1;
                    end
                end
            end
            else if (p < 67)
            begin
                r.func = nmdf_pkg::FUNC_TA;
            end
            else if (p < 77)
            begin
                r.func = nmdf_pkg::FUNC_CONRES;
            end
            else if (p < 85)
            begin
                r.func = nmdf_pkg::FUNC_READ;
            end
            else if (p < 95)
            begin
                r.func = nmdf_pkg::FUNC_FINISH;
            end
            else
            begin
                r.func = 3'($urandom_range(1, 7));
            end
        end
        if (r.func == nmdf_pkg::FUNC_BEGIN)
        begin
            pdu_open = 1'b1;
        end
        if (r.func == nmdf_pkg::FUNC_FINISH)
        begin
            pdu_open = 1'b0;
        end
    endtask

    // Result side: random backpressure, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go != hold_seen)
            begin
                hold_seen = hold_go;
                out_ready <= 1'b0;
                repeat (RX_HOLD) @(posedge clk);
            end
            else
            begin
                out_ready <= rx_fast || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Result checker and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cyc = 0;
            end
            else
            begin
                stall_cyc++;
            end
            if (stall_cyc >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, stall_cyc);
                $display("tb NOT OK");
                $finish;
            end
            else if (out_valid && out_ready)
            begin
                got = '{status, bytes_added, fill_level, read_byte};
                if (res_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result, none pending: %h", $time, got);
                end
                else
                begin
                    want = res_q.pop_front();
                    if (got !== want)
                    begin
                        err_cnt++;
                        $display("%0t: mismatch status exp %0d act %0d, %s %0d act %0d",
                                 $time, want.st, got.st, "bytes_added exp",
                                 want.added, got.added);
                        $display("%0t: fill_level exp %0d act %0d, %s %02h act %02h",
                                 $time, want.fill, got.fill, "read_byte exp",
                                 want.rbyte, got.rbyte);
                    end
                end
            end
        end
    end

    // Request side: reset, directed table, random PDUs, wind-down
    initial
    begin
        req_t r;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            for (int k = 0; k < dir_tab[i].reps; k++)
            begin
                r = dir_tab[i].r;
                if (dir_tab[i].reps > 1)
                begin
                    r.data = 8'($urandom_range(0, 255));
                end
                send_req(r, dir_tab[i].typed, dir_tab[i].want);
            end
        end
        drain(TAIL_CYC);

        for (int n = 0; n < N_RAND; n++)
        begin
            // back-to-back stretch on both sides
            if (n == 300)
            begin
                tx_fast = 1'b1;
                rx_fast = 1'b1;
            end
            if (n == 450)
            begin
                tx_fast = 1'b0;
                rx_fast = 1'b0;
            end
            // receiver stalls while requests keep coming
            if (n == 600)
            begin
                hold_go++;
            end
            // sender waits for the pipe to empty
            if (n == 900)
            begin
                drain(2);
            end
            pick_req(r);
            send_req(r, 1'b0, '0);
        end

        drain(TAIL_CYC);
        if (err_cnt == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/nmdf_pkg.sv
rtl/nmdf_pdu_ram.sv
rtl/nmdf_ctrl.sv
rtl/nr_mac_dl_pdu_framer.sv
dv/tb.sv
